>>> hw/rtl/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg: shared definitions for the wildcard prefix table match
// Table geometry, field widths, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int NUM_PATTERNS = 64;
  localparam int PATTERN_LEN  = 24;

  localparam int ENT_W   = $clog2(NUM_PATTERNS);
  localparam int CNT_W   = $clog2(NUM_PATTERNS + 1);
  localparam int POS_W   = $clog2(PATTERN_LEN + 1);
  localparam int DEPTH   = NUM_PATTERNS * PATTERN_LEN;
  localparam int ADDR_W  = $clog2(DEPTH);

  localparam int ENTRY_IDX_W = 6;
  localparam int CHAR_POS_W  = 5;
  localparam int CHAR_W      = 8;
  localparam int CFG_W       = 7;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_CHECK,
    ST_POST
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic write_mem;
    logic sweep_start;
    logic sweep_run;
    logic sweep_check;
    logic step_pos;
    logic set_ended;
    logic post_result;
    logic clear_query;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic ended;
    logic char_zero;
    logic last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hw/rtl/wpm_in_if.sv
// ----------------------------------------------------------------------------
// wpm_in_if: request channel of the wildcard prefix table match
// Carries load and query requests with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wpm_in_if;
  import wpm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [CHAR_POS_W-1:0]  char_position;
  logic [CHAR_W-1:0]      char_value;
  logic                   last_char;

  modport source (
    output valid, mode, entry_index, char_position, char_value, last_char,
    input  ready
  );

  modport sink (
    input  valid, mode, entry_index, char_position, char_value, last_char,
    output ready
  );

endinterface

>>> hw/rtl/wpm_out_if.sv
// ----------------------------------------------------------------------------
// wpm_out_if: result channel of the wildcard prefix table match
// Carries the match verdict of a finished query with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wpm_out_if;
  import wpm_pkg::*;

  logic             valid;
  logic             ready;
  logic             device_supported;
  logic [ENT_W-1:0] matched_entry;

  modport source (
    output valid, device_supported, matched_entry,
    input  ready
  );

  modport sink (
    input  valid, device_supported, matched_entry,
    output ready
  );

endinterface

>>> hw/rtl/wpm_ctrl.sv
// ----------------------------------------------------------------------------
// wpm_ctrl: sequencing controller
// Accepts requests, runs the per-byte update sweep and the final check sweep
// over the table, and posts the result when the output register is free.
// ----------------------------------------------------------------------------
module wpm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_ready,
  output wpm_pkg::dp_cmd_t cmd,
  input  wpm_pkg::dp_sts_t sts
);
  import wpm_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.write_mem = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        if (sts.ended || sts.char_zero) begin
          cmd.set_ended = sts.char_zero;
          if (sts.last) begin
            cmd.sweep_start = 1'b1;
            state_nxt       = ST_CHECK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.sweep_run = 1'b1;
        if (sts.sweep_done) begin
          cmd.step_pos = 1'b1;
          if (sts.last) begin
            cmd.sweep_start = 1'b1;
            state_nxt       = ST_CHECK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CHECK: begin
        cmd.sweep_run   = 1'b1;
        cmd.sweep_check = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (sts.out_free) begin
          cmd.post_result = 1'b1;
          cmd.clear_query = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/wpm_datapath.sv
// ----------------------------------------------------------------------------
// wpm_datapath: pattern store, per-entry match state and result register
// Holds the pattern memory with one registered read port, the alive and
// complete flags of every entry, the query position and the output register.
// ----------------------------------------------------------------------------
module wpm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wpm_pkg::dp_cmd_t                    cmd,
  output wpm_pkg::dp_sts_t                    sts,
  input  logic [wpm_pkg::ENTRY_IDX_W-1:0]     in_entry_index,
  input  logic [wpm_pkg::CHAR_POS_W-1:0]      in_char_position,
  input  logic [wpm_pkg::CHAR_W-1:0]          in_char_value,
  input  logic                                in_last_char,
  input  logic                                cfg_we,
  input  logic [wpm_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_device_supported,
  output logic [wpm_pkg::ENT_W-1:0]           out_matched_entry
);
  import wpm_pkg::*;

  localparam logic [CHAR_W-1:0] CH_ANY   = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h40;
  localparam logic [CHAR_W-1:0] CH_DIGIT = 8'h23;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_D0    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_D9    = 8'h39;

  function automatic logic byte_fits(input logic [CHAR_W-1:0] pb,
                                     input logic [CHAR_W-1:0] c);
    logic res;
    if (pb == CH_ANY) begin
      res = 1'b1;
    end else if (pb == CH_ALPHA) begin
      res = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    end else if (pb == CH_DIGIT) begin
      res = (c >= CH_D0) && (c <= CH_D9);
    end else begin
      res = (pb == c);
    end
    return res;
  endfunction

  logic [CHAR_W-1:0]       mem [DEPTH];
  logic [CHAR_W-1:0]       rd_r;

  logic [CFG_W-1:0]        entry_count_r;
  logic [CNT_W-1:0]        n_use;
  logic [CHAR_W-1:0]       char_r;
  logic                    last_r;
  logic [POS_W-1:0]        qpos_r;
  logic                    ended_r;
  logic [NUM_PATTERNS-1:0] alive_r, alive_nxt;
  logic [NUM_PATTERNS-1:0] complete_r, complete_nxt;
  logic [CNT_W-1:0]        iss_r;
  logic                    p_vld_r;
  logic [ENT_W-1:0]        p_e_r;
  logic                    found_r;
  logic [ENT_W-1:0]        which_r;
  logic                    out_valid_r;
  logic                    out_sup_r;
  logic [ENT_W-1:0]        out_ent_r;

  logic                    pos_end;
  logic [POS_W-1:0]        rd_pos;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       wr_addr;
  logic                    wr_ok;
  logic                    issue;
  logic [CHAR_W-1:0]       pb;
  logic                    hit;

  assign n_use = (int'(entry_count_r) > NUM_PATTERNS) ? CNT_W'(NUM_PATTERNS)
                                                       : CNT_W'(entry_count_r);

  assign pos_end = (qpos_r == POS_W'(PATTERN_LEN));
  assign rd_pos  = pos_end ? '0 : qpos_r;
  assign rd_addr = ADDR_W'(iss_r[ENT_W-1:0]) * ADDR_W'(PATTERN_LEN) + ADDR_W'(rd_pos);
  assign wr_addr = ADDR_W'(in_entry_index) * ADDR_W'(PATTERN_LEN)
                 + ADDR_W'(in_char_position);
  assign wr_ok   = (int'(in_entry_index) < NUM_PATTERNS)
                && (int'(in_char_position) < PATTERN_LEN);
  assign issue   = cmd.sweep_run && (iss_r < n_use);
  assign pb      = pos_end ? '0 : rd_r;
  assign hit     = complete_r[p_e_r] || (alive_r[p_e_r] && (pb == '0));

  always_ff @(posedge clk) begin
    if (cmd.write_mem && wr_ok) begin
      mem[wr_addr] <= in_char_value;
    end
    if (issue) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_r <= in_char_value;
      last_r <= in_last_char;
    end
    p_e_r <= iss_r[ENT_W-1:0];
  end

  always_comb begin
    alive_nxt    = alive_r;
    complete_nxt = complete_r;
    if (cmd.clear_query) begin
      alive_nxt    = '1;
      complete_nxt = '0;
    end else if (p_vld_r && !cmd.sweep_check && alive_r[p_e_r] && !complete_r[p_e_r]) begin
      if (pb == '0) begin
        complete_nxt[p_e_r] = 1'b1;
      end else if (!byte_fits(pb, char_r)) begin
        alive_nxt[p_e_r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r     <= '1;
      complete_r  <= '0;
      qpos_r      <= '0;
      ended_r     <= 1'b0;
      iss_r       <= '0;
      p_vld_r     <= 1'b0;
      found_r     <= 1'b0;
      which_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      alive_r    <= alive_nxt;
      complete_r <= complete_nxt;
      if (cmd.clear_query) begin
        qpos_r  <= '0;
        ended_r <= 1'b0;
      end else begin
        if (cmd.step_pos && !pos_end) begin
          qpos_r <= qpos_r + POS_W'(1);
        end
        if (cmd.set_ended) begin
          ended_r <= 1'b1;
        end
      end
      if (cmd.sweep_start) begin
        iss_r   <= '0;
        p_vld_r <= 1'b0;
        found_r <= 1'b0;
        which_r <= '0;
      end else begin
        if (issue) begin
          iss_r <= iss_r + CNT_W'(1);
        end
        p_vld_r <= issue;
        if (p_vld_r && cmd.sweep_check && hit && !found_r) begin
          found_r <= 1'b1;
          which_r <= p_e_r;
        end
      end
      if (cmd.post_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post_result) begin
      out_sup_r <= found_r;
      out_ent_r <= which_r;
    end
  end

  assign sts.sweep_done = (iss_r >= n_use) && !p_vld_r;
  assign sts.ended      = ended_r;
  assign sts.char_zero  = (char_r == '0);
  assign sts.last       = last_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_device_supported = out_sup_r;
  assign out_matched_entry    = out_ent_r;

  a_complete_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (complete_r & ~alive_r) == '0)
    else $error("complete entry not alive");

  a_read_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> $past(cmd.sweep_run))
    else $error("read data without a sweep");

  a_post_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post_result |=> out_valid_r)
    else $error("result not held after post");

  a_clear_query: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_query |=> (alive_r == '1) && (complete_r == '0) && (qpos_r == '0))
    else $error("query state not cleared");

endmodule

>>> hw/rtl/wildcard_prefix_table_match.sv
// ----------------------------------------------------------------------------
// wildcard_prefix_table_match: wildcard prefix match over a pattern table
// Pattern table loaded byte by byte, then matched against a streamed ID.
// ----------------------------------------------------------------------------
// in_chan (valid/ready) carries requests. mode 0 writes one pattern byte into
// entry entry_index at char_position. mode 1 streams one ID byte; unless a
// zero byte has ended the ID, every entry in use is updated for that byte in
// a sweep over the n entries in use (cfg_data, capped at the table size),
// since the pattern memory has one read port and serves one entry a cycle.
// A byte carrying last_char then runs a check sweep over the same entries
// and places one result on out_chan: device_supported and the lowest
// matching entry. No other request produces an output.
// cfg_we/cfg_data write the number of entries in use; write only while idle.
// Reset (rst_n low, synchronous) clears the entry count and the query state;
// the pattern memory keeps no reset and must be written before it is used.
// The result sits in an output register: requests are accepted while it
// waits, and only a further finished query holds until out_chan.ready frees
// the register.
// ----------------------------------------------------------------------------
module wildcard_prefix_table_match (
  input  logic                      clk,
  input  logic                      rst_n,
  wpm_in_if.sink                    in_chan,
  wpm_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [wpm_pkg::CFG_W-1:0] cfg_data
);
  import wpm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_chan.ready = in_ready;

  wpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_mode  (in_chan.mode),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  wpm_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_entry_index       (in_chan.entry_index),
    .in_char_position     (in_chan.char_position),
    .in_char_value        (in_chan.char_value),
    .in_last_char         (in_chan.last_char),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .out_ready            (out_chan.ready),
    .out_valid            (out_chan.valid),
    .out_device_supported (out_chan.device_supported),
    .out_matched_entry    (out_chan.matched_entry)
  );

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for the wildcard prefix table match
// Fills the whole pattern table, then runs a short directed set and a long
// randomised set of pattern loads and ID queries with random idling on both
// channels. A scoreboard class predicts every verdict and checks each one.
// ----------------------------------------------------------------------------
module tb_top;
  import wpm_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int IDLE_PCT       = 17;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 600;
  localparam int STEADY_PHASE   = 3;
  localparam int MAX_POSITION   = (1 << CHAR_POS_W) - 1;

  localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ANY      = "?";
  localparam logic [CHAR_W-1:0] CH_LETTER   = "@";
  localparam logic [CHAR_W-1:0] CH_DIGIT    = "#";
  localparam logic [CHAR_W-1:0] CH_LOWER_A  = "a";
  localparam logic [CHAR_W-1:0] CH_LOWER_Z  = "z";
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = "A";
  localparam logic [CHAR_W-1:0] CH_UPPER_Z  = "Z";
  localparam logic [CHAR_W-1:0] CH_ZERO     = "0";
  localparam logic [CHAR_W-1:0] CH_NINE     = "9";
  localparam logic [CHAR_W-1:0] HEADER_BASE = 8'h80;

  localparam logic [CFG_W-1:0] COUNT_NONE = '0;
  localparam logic [CFG_W-1:0] COUNT_ONE  = 7'd1;
  localparam logic [CFG_W-1:0] COUNT_TWO  = 7'd2;
  localparam logic [CFG_W-1:0] COUNT_FULL = CFG_W'(NUM_PATTERNS);
  localparam logic [CFG_W-1:0] COUNT_MAX  = '1;

  typedef struct packed {
    logic                   mode;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [CHAR_POS_W-1:0]  pos;
    logic [CHAR_W-1:0]      ch;
    logic                   last;
  } request_t;

  typedef struct packed {
    logic             supported;
    logic [ENT_W-1:0] entry;
  } verdict_t;

  class match_scoreboard;
    logic [CHAR_W-1:0] table_bytes [NUM_PATTERNS][PATTERN_LEN];
    bit                alive [NUM_PATTERNS];
    bit                complete [NUM_PATTERNS];
    int unsigned       query_pos;
    bit                ended;
    int unsigned       count;
    verdict_t          pending [$];
    int                errors;

    function new();
      clear_query();
      count  = 0;
      errors = 0;
    endfunction

    function void clear_query();
      for (int e = 0; e < NUM_PATTERNS; e++) begin
        alive[e]    = 1'b1;
        complete[e] = 1'b0;
      end
      query_pos = 0;
      ended     = 1'b0;
    endfunction

    function void set_count(logic [CFG_W-1:0] v);
      count = 32'(v);
    endfunction

    function int unsigned in_use();
      return (count > NUM_PATTERNS) ? NUM_PATTERNS : count;
    endfunction

    function logic [CHAR_W-1:0] pattern_at(int unsigned e, int unsigned p);
      if (p >= PATTERN_LEN) return CH_NUL;
      return table_bytes[e][p];
    endfunction

    function bit fits(logic [CHAR_W-1:0] pb, logic [CHAR_W-1:0] c);
      if (pb == CH_ANY) return 1'b1;
      if (pb == CH_LETTER)
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
      if (pb == CH_DIGIT) return c >= CH_ZERO && c <= CH_NINE;
      return pb == c;
    endfunction

    function void note_request(request_t r);
      int unsigned       n;
      logic [CHAR_W-1:0] pb;
      bit                found;
      int unsigned       which;
      verdict_t          v;
      n = in_use();
      if (r.mode == MODE_LOAD) begin
        if (r.pos < PATTERN_LEN) table_bytes[r.idx][r.pos] = r.ch;
        return;
      end
      if (!ended) begin
        if (r.ch == CH_NUL) begin
          ended = 1'b1;
        end else begin
          for (int e = 0; e < n; e++) begin
            if (alive[e] && !complete[e]) begin
              pb = pattern_at(e, query_pos);
              if (pb == CH_NUL) complete[e] = 1'b1;
              else if (!fits(pb, r.ch)) alive[e] = 1'b0;
            end
          end
          if (query_pos < PATTERN_LEN) query_pos++;
        end
      end
      if (!r.last) return;
      found = 1'b0;
      which = 0;
      for (int e = 0; e < n && !found; e++) begin
        if (complete[e] || (alive[e] && pattern_at(e, query_pos) == CH_NUL)) begin
          found = 1'b1;
          which = e;
        end
      end
      v.supported = found;
      v.entry     = which[ENT_W-1:0];
      pending.push_back(v);
      clear_query();
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        report($sformatf("verdict %0b/%0d with none pending", got.supported, got.entry));
      end else begin
        want = pending.pop_front();
        if (got.supported !== want.supported)
          report($sformatf("device_supported %0b, want %0b", got.supported, want.supported));
        if (got.entry !== want.entry)
          report($sformatf("matched_entry %0d, want %0d", got.entry, want.entry));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_data;
  bit                   steady;
  int unsigned          live_items;
  logic [CHAR_W-1:0]    id_bytes [$];
  match_scoreboard      sb = new();

  wpm_in_if  in_ch ();
  wpm_out_if out_ch ();

  wildcard_prefix_table_match dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request('{in_ch.mode, in_ch.entry_index, in_ch.char_position,
                        in_ch.char_value, in_ch.last_char});
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.device_supported, out_ch.matched_entry});
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] random_letter();
    int unsigned r;
    r = $urandom_range(51);
    return (r < 26) ? CH_LOWER_A + CHAR_W'(r) : CH_UPPER_A + CHAR_W'(r - 26);
  endfunction

  function automatic logic [CHAR_W-1:0] random_digit();
    return CH_ZERO + CHAR_W'($urandom_range(9));
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return CH_ANY;
    if (r < 35) return CH_LETTER;
    if (r < 50) return CH_DIGIT;
    if (r < 70) return random_letter();
    if (r < 85) return random_digit();
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [CHAR_W-1:0] fitting_byte(logic [CHAR_W-1:0] pb);
    if (pb == CH_ANY) return CHAR_W'($urandom_range(1, 255));
    if (pb == CH_LETTER) return random_letter();
    if (pb == CH_DIGIT) return random_digit();
    return pb;
  endfunction

  function automatic request_t load_req(int unsigned e, int unsigned p, logic [CHAR_W-1:0] c);
    return '{MODE_LOAD, e[ENTRY_IDX_W-1:0], p[CHAR_POS_W-1:0], c, 1'($urandom_range(1))};
  endfunction

  function automatic request_t query_req(logic [CHAR_W-1:0] c, bit last);
    return '{MODE_QUERY, ENTRY_IDX_W'($urandom), CHAR_POS_W'($urandom), c, last};
  endfunction

  function automatic request_t stray_load();
    return load_req($urandom_range(NUM_PATTERNS - 1), $urandom_range(MAX_POSITION),
                    CHAR_W'($urandom_range(255)));
  endfunction

  // build an ID that fits the entry as stored, then perturb it unless plain
  function automatic void make_id(int unsigned target, bit plain);
    int unsigned p;
    int unsigned r;
    id_bytes.delete();
    p = 0;
    while (p < PATTERN_LEN && sb.table_bytes[target][p] != CH_NUL) begin
      id_bytes.push_back(fitting_byte(sb.table_bytes[target][p]));
      p++;
    end
    if (!plain) begin
      r = $urandom_range(99);
      if (r < 20 && id_bytes.size() > 0)
        id_bytes[$urandom_range(id_bytes.size() - 1)] = CHAR_W'($urandom_range(1, 255));
      else if (r < 35 && id_bytes.size() > 1)
        id_bytes = id_bytes[0:$urandom_range(id_bytes.size() - 2)];
      else if (r < 45)
        id_bytes.insert($urandom_range(id_bytes.size()), CH_NUL);
      repeat ($urandom_range(3)) id_bytes.push_back(CHAR_W'($urandom_range(255)));
      if ($urandom_range(99) < 8)
        while (id_bytes.size() < PATTERN_LEN + 3)
          id_bytes.push_back(CHAR_W'($urandom_range(1, 255)));
    end
    if (id_bytes.size() == 0) id_bytes.push_back(CHAR_W'($urandom_range(255)));
  endfunction

  task automatic send(request_t r);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= r.mode;
    in_ch.entry_index   <= r.idx;
    in_ch.char_position <= r.pos;
    in_ch.char_value    <= r.ch;
    in_ch.last_char     <= r.last;
    do @(posedge clk); while (!in_ch.ready);
    if (r.mode == MODE_QUERY || r.pos < PATTERN_LEN) live_items++;
  endtask

  task automatic send_id(int lo, int hi, bit finish);
    for (int i = lo; i < hi; i++) begin
      if ($urandom_range(99) < 6) send(stray_load());
      send(query_req(id_bytes[i], finish && i == hi - 1));
    end
  endtask

  // len bytes of pattern, then a terminator; full also fills the tail
  task automatic write_pattern(int unsigned e, int unsigned len, logic [CHAR_W-1:0] head,
                               bit full);
    logic [CHAR_W-1:0] c;
    for (int unsigned p = 0; p < PATTERN_LEN; p++) begin
      if (p > len && !full) break;
      if (p < len) c = (p == 0 && head != CH_NUL) ? head : pattern_char();
      else if (p == len) c = CH_NUL;
      else c = CHAR_W'($urandom_range(255));
      send(load_req(e, p, c));
    end
  endtask

  // hold the sender until all verdicts are in and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_W-1:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_count(v);
  endtask

  function automatic logic [CFG_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return COUNT_NONE;
    if (r < 20) return COUNT_ONE;
    if (r < 32) return COUNT_FULL;
    if (r < 40) return COUNT_MAX;
    if (r < 48) return CFG_W'($urandom_range(NUM_PATTERNS + 1, (1 << CFG_W) - 1));
    return CFG_W'($urandom_range(COUNT_TWO, NUM_PATTERNS - 1));
  endfunction

  initial begin
    int unsigned phase_no;
    int unsigned n;
    int unsigned e;
    int unsigned r;
    int unsigned len;
    int          split;
    bit          open;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_data            <= COUNT_NONE;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= MODE_LOAD;
    in_ch.entry_index   <= '0;
    in_ch.char_position <= '0;
    in_ch.char_value    <= CH_NUL;
    in_ch.last_char     <= 1'b0;
    steady              = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every byte of the table; each entry opens with its own header byte
    for (int unsigned i = 0; i < NUM_PATTERNS; i++)
      write_pattern(i, (i % 16 == 15) ? PATTERN_LEN : $urandom_range(1, 8),
                    HEADER_BASE + CHAR_W'(i), 1'b1);

    write_cfg(COUNT_FULL);
    make_id(NUM_PATTERNS - 1, 1'b1);
    send_id(0, id_bytes.size(), 1'b1);
    send(query_req(CH_NUL, 1'b1));
    send(load_req(3, PATTERN_LEN, 8'h55));
    send(load_req(3, MAX_POSITION, 8'hAA));
    write_pattern(1, 1, CH_ANY, 1'b0);
    make_id(9, 1'b1);
    send_id(0, id_bytes.size(), 1'b1);
    write_pattern(1, 3, HEADER_BASE + CHAR_W'(1), 1'b0);
    make_id(7, 1'b1);
    split = id_bytes.size() / 2;
    send_id(0, split, 1'b0);
    send(load_req(7, 0, 8'h01));
    send_id(split, id_bytes.size(), 1'b1);
    write_cfg(COUNT_MAX);
    make_id(NUM_PATTERNS - 2, 1'b1);
    send_id(0, id_bytes.size(), 1'b1);
    write_cfg(COUNT_NONE);
    make_id(0, 1'b1);
    send_id(0, id_bytes.size(), 1'b1);
    write_cfg(COUNT_TWO);
    make_id(40, 1'b1);
    if (id_bytes.size() < 2) id_bytes.push_back(random_letter());
    send_id(0, 1, 1'b0);
    write_cfg(COUNT_FULL);
    send_id(1, id_bytes.size(), 1'b1);

    live_items = 0;
    phase_no   = 0;
    open       = 1'b0;
    while (live_items < RANDOM_ITEMS || open) begin
      phase_no++;
      steady = (phase_no == STEADY_PHASE);
      write_cfg(pick_count());
      if (open) begin
        send_id(split, id_bytes.size(), 1'b1);
        open = 1'b0;
      end
      n = sb.in_use();
      repeat ($urandom_range(3, 8)) begin
        r = $urandom_range(99);
        if (r < 15) begin
          e = (n > 0 && $urandom_range(1)) ? $urandom_range(n - 1)
                                           : $urandom_range(NUM_PATTERNS - 1);
          r = $urandom_range(99);
          len = (r < 3) ? 0 : (r < 12) ? PATTERN_LEN : $urandom_range(1, 8);
          write_pattern(e, len, $urandom_range(1) ? HEADER_BASE + CHAR_W'(e) : CH_NUL,
                        1'b0);
        end else if (r < 20) begin
          repeat ($urandom_range(1, 4)) send(stray_load());
        end else begin
          make_id((n > 0) ? $urandom_range(n - 1) : $urandom_range(NUM_PATTERNS - 1), 1'b0);
          send_id(0, id_bytes.size(), 1'b1);
        end
      end
      // leave a query open across the next count change
      if ($urandom_range(99) < 25) begin
        make_id((n > 0) ? $urandom_range(n - 1) : $urandom_range(NUM_PATTERNS - 1), 1'b0);
        if (id_bytes.size() >= 2) begin
          split = $urandom_range(1, id_bytes.size() - 1);
          send_id(0, split, 1'b0);
          open = 1'b1;
        end
      end
    end
    steady = 1'b0;

    settle();
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
